>>> src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helpers for the Playfair digraph cipher engine.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int LETTER_W    = 5;
  localparam int CELL_W      = 5;
  localparam int ROW_W       = 3;
  localparam int SQ_SIDE     = 5;
  localparam int SQ_CELLS    = 25;
  localparam int ALPHA       = 26;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
  localparam logic [LETTER_W-1:0] DEFAULT_PAD = 5'd23;
  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
  localparam logic [CELL_W-1:0]   FULL_COUNT  = 5'd25;
  localparam logic [ROW_W-1:0]    LAST_IDX    = 3'd4;

  // input opcodes
  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_MSG  = 2'd2;
  localparam logic [1:0] OP_END  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LETTER   = 1'b1;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [LETTER_W-1:0] letter;
  } item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic                pair_end;
  } result_t;

  // one digraph waiting for lookup
  typedef struct packed {
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
  } pair_t;

  // square build write, shared by both lookup memories
  typedef struct packed {
    logic                we;
    logic [LETTER_W-1:0] letter;
    logic [CELL_W-1:0]   slot;
  } place_t;

  // pad with out-of-range and j folded
  function automatic logic [LETTER_W-1:0] eff_pad(input logic [LETTER_W-1:0] p);
    logic [LETTER_W-1:0] r;
    r = (p > LAST_LETTER) ? DEFAULT_PAD : p;
    if (r == LETTER_J) r = LETTER_I;
    return r;
  endfunction

  // cell / 5 for cells 0..24 via reciprocal multiply (x*13 >> 6)
  function automatic logic [ROW_W-1:0] cell_row(input logic [CELL_W-1:0] c);
    logic [8:0] prod;
    prod = {4'b0, c} * 9'd13;
    return prod[8:6];
  endfunction

  function automatic logic [ROW_W-1:0] cell_col(input logic [CELL_W-1:0] c);
    logic [ROW_W-1:0] r;
    logic [CELL_W-1:0] d;
    r = cell_row(c);
    d = c - {r, 2'b00} - {2'b00, r};
    return d[ROW_W-1:0];
  endfunction

  function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [ROW_W-1:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // cyclic shift by one along a row or column
  function automatic logic [ROW_W-1:0] shift_idx(input logic [ROW_W-1:0] v,
                                                 input logic back);
    logic [ROW_W-1:0] r;
    if (back) r = (v == '0) ? LAST_IDX : v - 3'd1;
    else      r = (v == LAST_IDX) ? '0 : v + 3'd1;
    return r;
  endfunction

endpackage

>>> src/pfc_ram.sv
// ----------------------------------------------------------------------------
// pfc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Accepts item beats, builds the key square and pairs message letters
// into digraphs that are pushed to the lookup queue.
// ----------------------------------------------------------------------------
module pfc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  pfc_pkg::item_t                item,
  input  logic [pfc_pkg::LETTER_W-1:0]  pad_letter,
  output pfc_pkg::place_t               place,
  output logic                          pair_push,
  output pfc_pkg::pair_t                pair,
  input  logic                          q_full
);
  import pfc_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_FILL = 2'b10
  } front_state_t;

  front_state_t        state, state_next;
  logic [ALPHA-1:0]    letter_used;
  logic [CELL_W-1:0]   fill_count;
  logic [LETTER_W-1:0] fill_idx;
  logic [LETTER_W-1:0] held_letter, held_letter_next;
  logic                held_valid, held_valid_next;
  logic                square_ready;

  logic                accept;
  logic [LETTER_W-1:0] cand;
  logic                cand_used;
  logic                cand_ok;
  logic [LETTER_W-1:0] msg_letter;
  logic                start_fill;

  assign item_ready = (state == F_IDLE) && !q_full;
  assign accept     = item_valid && item_ready;

  // candidate letter for the square: walk index while filling, else key letter
  assign cand      = (state == F_FILL) ? fill_idx : item.letter;
  assign cand_used = (cand <= LAST_LETTER) ? letter_used[cand] : 1'b1;
  assign cand_ok   = (fill_count < FULL_COUNT) && (cand != LETTER_J) && !cand_used;

  assign place.we     = cand_ok && ((state == F_FILL) ||
                        (accept && item.opcode == OP_KEY && !square_ready));
  assign place.letter = cand;
  assign place.slot   = fill_count;

  assign msg_letter = (item.letter == LETTER_J) ? LETTER_I : item.letter;
  assign start_fill = accept && item.opcode == OP_FILL && !square_ready;

  // digraph pairing
  always_comb begin
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    pair_push        = 1'b0;
    pair.first       = held_letter;
    pair.second      = eff_pad(pad_letter);
    if (accept) begin
      case (item.opcode)
        OP_MSG: begin
          if (square_ready && item.letter <= LAST_LETTER) begin
            if (!held_valid) begin
              held_letter_next = msg_letter;
              held_valid_next  = 1'b1;
            end else if (held_letter == msg_letter) begin
              pair_push = 1'b1;
            end else begin
              pair_push       = 1'b1;
              pair.second     = msg_letter;
              held_valid_next = 1'b0;
            end
          end
        end
        OP_END: begin
          if (held_valid) begin
            pair_push       = 1'b1;
            held_valid_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // fill sequencer
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (start_fill) state_next = F_FILL;
      F_FILL: if (fill_idx == LAST_LETTER) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      letter_used  <= '0;
      fill_count   <= '0;
      fill_idx     <= '0;
      held_letter  <= '0;
      held_valid   <= 1'b0;
      square_ready <= 1'b0;
    end else begin
      state       <= state_next;
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
      if (place.we) begin
        letter_used[cand] <= 1'b1;
        fill_count        <= fill_count + 5'd1;
      end
      if (start_fill) fill_idx <= '0;
      else if (state == F_FILL) fill_idx <= fill_idx + 5'd1;
      if (state == F_FILL && fill_idx == LAST_LETTER) square_ready <= 1'b1;
    end
  end

  // the walk always completes a full square
  a_full_square: assert property (@(posedge clk) disable iff (rst)
    $rose(square_ready) |-> fill_count == FULL_COUNT)
    else $error("square ready with incomplete fill");

  // no message letter is held before the square exists
  a_held_ready: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> square_ready)
    else $error("held letter without ready square");

endmodule

>>> src/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// Short FIFO of digraphs between the front and the lookup back end.
// ----------------------------------------------------------------------------
module pfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pfc_pkg::pair_t wdata,
  input  logic           pop,
  output pfc_pkg::pair_t head,
  output logic           full,
  output logic           empty
);
  import pfc_pkg::*;

  pair_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

>>> src/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Looks up both letters of a digraph, applies the Playfair rules and
// sends the two result beats.
// ----------------------------------------------------------------------------
module pfc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         decrypt_mode,
  input  pfc_pkg::pair_t               head,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic [pfc_pkg::LETTER_W-1:0] pos_raddr_a,
  output logic [pfc_pkg::LETTER_W-1:0] pos_raddr_b,
  input  logic [pfc_pkg::CELL_W-1:0]   pos_rdata_a,
  input  logic [pfc_pkg::CELL_W-1:0]   pos_rdata_b,
  output logic [pfc_pkg::CELL_W-1:0]   sq_raddr_a,
  output logic [pfc_pkg::CELL_W-1:0]   sq_raddr_b,
  input  logic [pfc_pkg::LETTER_W-1:0] sq_rdata_a,
  input  logic [pfc_pkg::LETTER_W-1:0] sq_rdata_b,
  output logic                         result_valid,
  input  logic                         result_ready,
  output pfc_pkg::result_t             result
);
  import pfc_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_POS   = 5'b00010,
    B_CELL  = 5'b00100,
    B_EMIT0 = 5'b01000,
    B_EMIT1 = 5'b10000
  } back_state_t;

  back_state_t         state, state_next;
  logic [LETTER_W-1:0] x_letter, y_letter;
  logic [ROW_W-1:0]    ra, ca, rb, cb;

  assign q_pop       = (state == B_IDLE) && !q_empty;
  assign pos_raddr_a = head.first;
  assign pos_raddr_b = head.second;

  // square coordinates and Playfair rule selection
  always_comb begin
    ra = cell_row(pos_rdata_a);
    ca = cell_col(pos_rdata_a);
    rb = cell_row(pos_rdata_b);
    cb = cell_col(pos_rdata_b);
    if (ra == rb) begin
      sq_raddr_a = cell_index(ra, shift_idx(ca, decrypt_mode));
      sq_raddr_b = cell_index(rb, shift_idx(cb, decrypt_mode));
    end else if (ca == cb) begin
      sq_raddr_a = cell_index(shift_idx(ra, decrypt_mode), ca);
      sq_raddr_b = cell_index(shift_idx(rb, decrypt_mode), cb);
    end else begin
      sq_raddr_a = cell_index(ra, cb);
      sq_raddr_b = cell_index(rb, ca);
    end
  end

  assign result_valid      = (state == B_EMIT0) || (state == B_EMIT1);
  assign result.out_letter = (state == B_EMIT1) ? y_letter : x_letter;
  assign result.pair_end   = (state == B_EMIT1);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!q_empty) state_next = B_POS;
      B_POS:   state_next = B_CELL;
      B_CELL:  state_next = B_EMIT0;
      B_EMIT0: if (result_ready) state_next = B_EMIT1;
      B_EMIT1: if (result_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == B_CELL) begin
      x_letter <= sq_rdata_a;
      y_letter <= sq_rdata_b;
    end
  end

  // a first beat taken is always followed by the second beat of the pair
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.pair_end |=>
      result_valid && result.pair_end)
    else $error("second letter of digraph missing");

endmodule

>>> src/playfair_digraph_cipher.sv
// A message beat that completes a digraph is queued; the back end pops it,
// passes through B_POS and B_CELL for the lookups, then gives the result beats.
// The lookup back end takes a new digraph only after both beats of the last one
// are taken; the front takes one beat per cycle while the 2-entry queue has room
// and no key fill runs. Key fill walks all 26 letters with no input beats taken.
// Reset (synchronous) clears control state; square memories are not cleared.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher engine: key square build, digraph pairing and lookup.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  pfc_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output pfc_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfc_pkg::*;

  logic                decrypt_mode;
  logic [LETTER_W-1:0] pad_letter;

  place_t              place;
  logic                pair_push;
  pair_t               pair_in, pair_head;
  logic                q_full, q_empty, q_pop;
  logic [LETTER_W-1:0] pos_raddr_a, pos_raddr_b;
  logic [CELL_W-1:0]   pos_rdata_a, pos_rdata_b;
  logic [CELL_W-1:0]   sq_raddr_a, sq_raddr_b;
  logic [LETTER_W-1:0] sq_rdata_a, sq_rdata_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      pad_letter   <= DEFAULT_PAD;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DECRYPT_MODE: decrypt_mode <= cfg_wdata[0];
        REG_PAD_LETTER:   pad_letter   <= cfg_wdata[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  pfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .pad_letter (pad_letter),
    .place      (place),
    .pair_push  (pair_push),
    .pair       (pair_in),
    .q_full     (q_full)
  );

  pfc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (pair_push),
    .wdata (pair_in),
    .pop   (q_pop),
    .head  (pair_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // letter -> cell index
  pfc_ram #(.WIDTH(CELL_W), .DEPTH(ALPHA)) u_pos_ram (
    .clk     (clk),
    .we      (place.we),
    .waddr   (place.letter),
    .wdata   (place.slot),
    .raddr_a (pos_raddr_a),
    .raddr_b (pos_raddr_b),
    .rdata_a (pos_rdata_a),
    .rdata_b (pos_rdata_b)
  );

  // cell index -> letter
  pfc_ram #(.WIDTH(LETTER_W), .DEPTH(SQ_CELLS)) u_square_ram (
    .clk     (clk),
    .we      (place.we),
    .waddr   (place.slot),
    .wdata   (place.letter),
    .raddr_a (sq_raddr_a),
    .raddr_b (sq_raddr_b),
    .rdata_a (sq_rdata_a),
    .rdata_b (sq_rdata_b)
  );

  pfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .decrypt_mode (decrypt_mode),
    .head         (pair_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pos_raddr_a  (pos_raddr_a),
    .pos_raddr_b  (pos_raddr_b),
    .pos_rdata_a  (pos_rdata_a),
    .pos_rdata_b  (pos_rdata_b),
    .sq_raddr_a   (sq_raddr_a),
    .sq_raddr_b   (sq_raddr_b),
    .sq_rdata_a   (sq_rdata_a),
    .sq_rdata_b   (sq_rdata_b),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
